// File: design/decimal_number_text_parser_assert.svh
// Assertion macros shared by the decimal number text parser modules.
// Each macro expects signals named clk and rst in the including scope.
`ifndef DECIMAL_NUMBER_TEXT_PARSER_ASSERT_SVH
`define DECIMAL_NUMBER_TEXT_PARSER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define DNTP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, implies another in the next cycle.
`define DNTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dntp_pkg.sv
// Package for the decimal number text parser.
// Holds the character class type, the queue item type and character codes.
// No dependencies.
`default_nettype none

package dntp_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;

  localparam int MANT_W = 60;
  localparam int EXP_W = 10;
  localparam int FRAC_W = 8;
  localparam int DEXP_W = 12;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_MINUS,
    CLS_PLUS,
    CLS_DIGIT,
    CLS_POINT,
    CLS_EXPMARK,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       last;
  } item_t;

  function automatic logic [63:0] mant_limit(input int digits);
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < 19; k++) begin
      if (k < digits) begin
        p = p * 64'd10;
      end
    end
    p = p - 64'd1;
    if (p > {4'h0, {MANT_W{1'b1}}}) begin
      p = {4'h0, {MANT_W{1'b1}}};
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: design/dntp_front.sv
// Front end of the decimal number text parser: accepts characters and
// classifies them into queue items. Depends on dntp_pkg.
`default_nettype none

module dntp_front (
  input  wire logic           push,
  output logic                full,
  input  wire logic [7:0]     char_code,
  input  wire logic           last_char,
  output logic                q_push,
  output dntp_pkg::item_t     q_item,
  input  wire logic           q_full
);
  import dntp_pkg::*;

  assign full = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item.last = last_char;
    q_item.digit = 4'd0;
    if (char_code inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
      q_item.cls = CLS_SPACE;
    end else if (char_code == CH_MINUS) begin
      q_item.cls = CLS_MINUS;
    end else if (char_code == CH_PLUS) begin
      q_item.cls = CLS_PLUS;
    end else if (char_code inside {[CH_ZERO:CH_NINE]}) begin
      q_item.cls = CLS_DIGIT;
      q_item.digit = 4'(char_code - CH_ZERO);
    end else if (char_code == CH_POINT) begin
      q_item.cls = CLS_POINT;
    end else if (char_code inside {CH_LOWER_E, CH_UPPER_E}) begin
      q_item.cls = CLS_EXPMARK;
    end else begin
      q_item.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

// File: design/dntp_queue.sv
// Small register queue between front and back of the parser.
// Depends on dntp_pkg and the assertion macro header.
`default_nettype none
`include "decimal_number_text_parser_assert.svh"

module dntp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire dntp_pkg::item_t wr_item,
  output logic                 q_full,
  output logic                 rd_valid,
  output dntp_pkg::item_t      rd_item,
  input  wire logic            rd_en
);
  import dntp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item = slots[rd_ptr];
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `DNTP_ASSERT_ALWAYS(a_empty_ptrs, (count != '0) || (rd_ptr == wr_ptr), "queue empty but pointers differ")

endmodule

`default_nettype wire

// File: design/dntp_back.sv
// Back end of the decimal number text parser: the scan state machine,
// the mantissa and exponent accumulators and the result register.
// Depends on dntp_pkg and the assertion macro header.
`default_nettype none
`include "decimal_number_text_parser_assert.svh"

module dntp_back #(
  parameter int MAX_DIGITS = 18,
  parameter int MAX_EXP = 999
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire dntp_pkg::item_t        in_item,
  output logic                        in_ready,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        negative,
  output logic [dntp_pkg::MANT_W-1:0] mantissa,
  output logic signed [dntp_pkg::DEXP_W-1:0] decimal_exponent,
  output logic                        overflow
);
  import dntp_pkg::*;

  localparam logic [63:0] MANT_LIMIT = mant_limit(MAX_DIGITS);
  localparam logic [EXP_W-1:0] EXP_LIMIT = EXP_W'(MAX_EXP);
  localparam int EPROD_W = EXP_W + 4;

  typedef enum logic [5:0] {
    PH_SPACE = 6'b000001,
    PH_INT   = 6'b000010,
    PH_FRAC  = 6'b000100,
    PH_ESIGN = 6'b001000,
    PH_EXP   = 6'b010000,
    PH_STOP  = 6'b100000
  } phase_t;

  phase_t              phase;
  phase_t              phase_next;
  logic [MANT_W-1:0]   mantissa_acc;
  logic [MANT_W-1:0]   mantissa_acc_next;
  logic [FRAC_W-1:0]   fraction_count;
  logic [FRAC_W-1:0]   fraction_count_next;
  logic [EXP_W-1:0]    exponent_acc;
  logic [EXP_W-1:0]    exponent_acc_next;
  logic                minus_seen;
  logic                minus_seen_next;
  logic                exp_minus_seen;
  logic                exp_minus_seen_next;
  logic                saturated;
  logic                saturated_next;

  logic                out_valid;
  logic                out_negative;
  logic [MANT_W-1:0]   out_mantissa;
  logic [EXP_W-1:0]    out_exponent;
  logic                out_exp_minus;
  logic [FRAC_W-1:0]   out_fraction;
  logic                out_overflow;

  logic                take;
  logic [63:0]         mant_prod;
  logic [EPROD_W-1:0]  exp_prod;
  logic                mant_over;
  logic                exp_over;
  logic                add_mant;
  logic                add_exp;
  logic                add_frac;
  logic signed [DEXP_W-1:0] exp_signed;

  assign in_ready = !(in_item.last && out_valid && !pop);
  assign take = in_valid && in_ready;

  assign mant_prod = ({4'h0, mantissa_acc} << 3) + ({4'h0, mantissa_acc} << 1)
                     + {60'd0, in_item.digit};
  assign mant_over = (mant_prod > MANT_LIMIT);
  assign exp_prod = ({4'h0, exponent_acc} << 3) + ({4'h0, exponent_acc} << 1)
                    + {{(EPROD_W-4){1'b0}}, in_item.digit};
  assign exp_over = (exp_prod > {4'h0, EXP_LIMIT});

  always_comb begin
    phase_next = phase;
    minus_seen_next = minus_seen;
    exp_minus_seen_next = exp_minus_seen;
    add_mant = 1'b0;
    add_exp = 1'b0;
    add_frac = 1'b0;
    case (phase)
      PH_SPACE: begin
        case (in_item.cls)
          CLS_SPACE: phase_next = PH_SPACE;
          CLS_MINUS: begin
            minus_seen_next = 1'b1;
            phase_next = PH_INT;
          end
          CLS_PLUS: phase_next = PH_INT;
          CLS_DIGIT: begin
            add_mant = 1'b1;
            phase_next = PH_INT;
          end
          CLS_POINT: phase_next = PH_FRAC;
          CLS_EXPMARK: phase_next = PH_ESIGN;
          default: phase_next = PH_STOP;
        endcase
      end
      PH_INT: begin
        case (in_item.cls)
          CLS_DIGIT: add_mant = 1'b1;
          CLS_POINT: phase_next = PH_FRAC;
          CLS_EXPMARK: phase_next = PH_ESIGN;
          default: phase_next = PH_STOP;
        endcase
      end
      PH_FRAC: begin
        case (in_item.cls)
          CLS_DIGIT: begin
            add_mant = 1'b1;
            add_frac = 1'b1;
          end
          CLS_EXPMARK: phase_next = PH_ESIGN;
          default: phase_next = PH_STOP;
        endcase
      end
      PH_ESIGN: begin
        case (in_item.cls)
          CLS_MINUS: begin
            exp_minus_seen_next = 1'b1;
            phase_next = PH_EXP;
          end
          CLS_PLUS: phase_next = PH_EXP;
          CLS_DIGIT: begin
            add_exp = 1'b1;
            phase_next = PH_EXP;
          end
          default: phase_next = PH_STOP;
        endcase
      end
      PH_EXP: begin
        if (in_item.cls == CLS_DIGIT) begin
          add_exp = 1'b1;
        end else begin
          phase_next = PH_STOP;
        end
      end
      default: phase_next = PH_STOP;
    endcase

    mantissa_acc_next = mantissa_acc;
    exponent_acc_next = exponent_acc;
    fraction_count_next = fraction_count;
    saturated_next = saturated;
    if (add_mant) begin
      if (mant_over) begin
        mantissa_acc_next = MANT_LIMIT[MANT_W-1:0];
        saturated_next = 1'b1;
      end else begin
        mantissa_acc_next = mant_prod[MANT_W-1:0];
      end
    end
    if (add_frac) begin
      if (fraction_count == {FRAC_W{1'b1}}) begin
        saturated_next = 1'b1;
      end else begin
        fraction_count_next = fraction_count + 1'b1;
      end
    end
    if (add_exp) begin
      if (exp_over) begin
        exponent_acc_next = EXP_LIMIT;
        saturated_next = 1'b1;
      end else begin
        exponent_acc_next = exp_prod[EXP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      mantissa_acc <= '0;
      fraction_count <= '0;
      exponent_acc <= '0;
      minus_seen <= 1'b0;
      exp_minus_seen <= 1'b0;
      saturated <= 1'b0;
    end else if (take) begin
      if (in_item.last) begin
        phase <= PH_SPACE;
        mantissa_acc <= '0;
        fraction_count <= '0;
        exponent_acc <= '0;
        minus_seen <= 1'b0;
        exp_minus_seen <= 1'b0;
        saturated <= 1'b0;
      end else begin
        phase <= phase_next;
        mantissa_acc <= mantissa_acc_next;
        fraction_count <= fraction_count_next;
        exponent_acc <= exponent_acc_next;
        minus_seen <= minus_seen_next;
        exp_minus_seen <= exp_minus_seen_next;
        saturated <= saturated_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && in_item.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_item.last) begin
      out_negative <= minus_seen_next;
      out_mantissa <= mantissa_acc_next;
      out_exponent <= exponent_acc_next;
      out_exp_minus <= exp_minus_seen_next;
      out_fraction <= fraction_count_next;
      out_overflow <= saturated_next;
    end
  end

  assign exp_signed = $signed({{(DEXP_W-EXP_W){1'b0}}, out_exponent});
  assign empty = !out_valid;
  assign negative = out_negative;
  assign mantissa = out_mantissa;
  assign overflow = out_overflow;
  assign decimal_exponent = (out_exp_minus ? -exp_signed : exp_signed)
                            - $signed({{(DEXP_W-FRAC_W){1'b0}}, out_fraction});

  `DNTP_ASSERT_ALWAYS(a_mant_limit, {4'h0, mantissa_acc} <= MANT_LIMIT, "mantissa above limit")
  `DNTP_ASSERT_ALWAYS(a_exp_limit, exponent_acc <= EXP_LIMIT, "exponent above limit")
  `DNTP_ASSERT_NEXT(a_last_clears, take && in_item.last, (phase == PH_SPACE) && (mantissa_acc == '0) && out_valid, "state not cleared after last character")

endmodule

`default_nettype wire

// File: design/decimal_number_text_parser.sv
// Decimal number text parser, one character per cycle while full is low.
// A last character is queued; the scanner then loads the result register from it.
// Throughput: one character per cycle; the queue between classifier and scanner
// fills only while a finished result waits unread and a further last character arrives.
// Reset: synchronous rst empties the item queue and the result register and returns
// the scanner to whitespace skipping.
`default_nettype none

module decimal_number_text_parser #(
  parameter int MAX_DIGITS = 18,
  parameter int MAX_EXP = 999,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             char_code,
  input  wire logic                   last_char,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        negative,
  output logic [dntp_pkg::MANT_W-1:0] mantissa,
  output logic signed [dntp_pkg::DEXP_W-1:0] decimal_exponent,
  output logic                        overflow
);
  import dntp_pkg::*;

  logic  q_push;
  item_t q_item;
  logic  q_full;
  logic  rd_valid;
  item_t rd_item;
  logic  rd_en;

  dntp_front u_front (
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last_char (last_char),
    .q_push    (q_push),
    .q_item    (q_item),
    .q_full    (q_full)
  );

  dntp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_item  (q_item),
    .q_full   (q_full),
    .rd_valid (rd_valid),
    .rd_item  (rd_item),
    .rd_en    (rd_en)
  );

  dntp_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_EXP    (MAX_EXP)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (rd_valid),
    .in_item          (rd_item),
    .in_ready         (rd_en),
    .empty            (empty),
    .pop              (pop),
    .negative         (negative),
    .mantissa         (mantissa),
    .decimal_exponent (decimal_exponent),
    .overflow         (overflow)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for decimal_number_text_parser: number texts in, parsed fields out.
// A scoreboard class predicts sign, mantissa, decimal exponent and overflow per text.
// Depends on dntp_pkg and the decimal_number_text_parser module.
`timescale 1ns / 1ps

module tb;
  import dntp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CHARS_PER_PHASE = 550;
  localparam logic [63:0] MANT_MAX = 64'd999_999_999_999_999_999;
  localparam int unsigned EXP_MAX = 999;

  typedef enum logic [2:0] {
    SCAN_WS,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_ESIGN,
    SCAN_EXP,
    SCAN_STOP
  } scan_phase_t;

  typedef struct {
    logic                     neg;
    logic [MANT_W-1:0]        mant;
    logic signed [DEXP_W-1:0] dexp;
    logic                     ovf;
  } number_t;

  class number_scoreboard;
    scan_phase_t phase;
    logic [63:0] mant_acc;
    int unsigned frac_count;
    int unsigned exp_acc;
    bit minus_seen;
    bit exp_minus;
    bit sat;
    number_t expected_q[$];
    int errors;
    int checked;
    int overflows;

    function new();
      clear_scan();
      errors = 0;
      checked = 0;
      overflows = 0;
    endfunction

    function void clear_scan();
      phase = SCAN_WS;
      mant_acc = 64'd0;
      frac_count = 0;
      exp_acc = 0;
      minus_seen = 0;
      exp_minus = 0;
      sat = 0;
    endfunction

    function void add_mant_digit(int unsigned d);
      if (mant_acc > MANT_MAX || mant_acc > (MANT_MAX - d) / 64'd10) begin
        mant_acc = MANT_MAX;
        sat = 1;
      end else begin
        mant_acc = mant_acc * 64'd10 + d;
      end
    endfunction

    function void add_exp_digit(int unsigned d);
      int unsigned v;
      v = exp_acc * 10 + d;
      if (exp_acc > EXP_MAX || v > EXP_MAX) begin
        exp_acc = EXP_MAX;
        sat = 1;
      end else begin
        exp_acc = v;
      end
    endfunction

    function void note_char(logic [7:0] c, logic is_last);
      bit is_digit;
      bit is_mark;
      bit is_ws;
      int unsigned d;
      int e;
      number_t want;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d = is_digit ? int'(c - CH_ZERO) : 0;
      is_mark = (c == CH_LOWER_E) || (c == CH_UPPER_E);
      is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      case (phase)
        SCAN_WS: begin
          if (is_ws) begin
            phase = SCAN_WS;
          end else if (c == CH_MINUS) begin
            minus_seen = 1;
            phase = SCAN_INT;
          end else if (c == CH_PLUS) begin
            phase = SCAN_INT;
          end else if (is_digit) begin
            add_mant_digit(d);
            phase = SCAN_INT;
          end else if (c == CH_POINT) begin
            phase = SCAN_FRAC;
          end else if (is_mark) begin
            phase = SCAN_ESIGN;
          end else begin
            phase = SCAN_STOP;
          end
        end
        SCAN_INT: begin
          if (is_digit) add_mant_digit(d);
          else if (c == CH_POINT) phase = SCAN_FRAC;
          else if (is_mark) phase = SCAN_ESIGN;
          else phase = SCAN_STOP;
        end
        SCAN_FRAC: begin
          if (is_digit) begin
            add_mant_digit(d);
            if (frac_count >= 255) sat = 1;
            else frac_count++;
          end else if (is_mark) begin
            phase = SCAN_ESIGN;
          end else begin
            phase = SCAN_STOP;
          end
        end
        SCAN_ESIGN: begin
          if (c == CH_MINUS) begin
            exp_minus = 1;
            phase = SCAN_EXP;
          end else if (c == CH_PLUS) begin
            phase = SCAN_EXP;
          end else if (is_digit) begin
            add_exp_digit(d);
            phase = SCAN_EXP;
          end else begin
            phase = SCAN_STOP;
          end
        end
        SCAN_EXP: begin
          if (is_digit) add_exp_digit(d);
          else phase = SCAN_STOP;
        end
        default: phase = SCAN_STOP;
      endcase
      if (is_last) begin
        e = exp_minus ? -int'(exp_acc) : int'(exp_acc);
        e -= int'(frac_count);
        if (e < -2048) e = -2048;
        if (e > 2047) e = 2047;
        want.neg = minus_seen;
        want.mant = mant_acc[MANT_W-1:0];
        want.dexp = DEXP_W'(e);
        want.ovf = sat;
        if (sat) overflows++;
        expected_q.push_back(want);
        clear_scan();
      end
    endfunction

    function void check_result(logic neg, logic [MANT_W-1:0] mant,
                               logic signed [DEXP_W-1:0] dexp, logic ovf);
      number_t want;
      if (expected_q.size() == 0) begin
        $error("Result transfer with no parsed text outstanding.");
        errors++;
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (neg !== want.neg) begin
          $error("negative: expected %0d, got %0d", want.neg, neg);
          errors++;
        end
        if (mant !== want.mant) begin
          $error("mantissa: expected %0d, got %0d", want.mant, mant);
          errors++;
        end
        if (dexp !== want.dexp) begin
          $error("decimal_exponent: expected %0d, got %0d", want.dexp, dexp);
          errors++;
        end
        if (ovf !== want.ovf) begin
          $error("overflow: expected %0d, got %0d", want.ovf, ovf);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [7:0] char_code;
  logic last_char;
  logic empty;
  logic pop;
  logic negative;
  logic [MANT_W-1:0] mantissa;
  logic signed [DEXP_W-1:0] decimal_exponent;
  logic overflow;

  number_scoreboard sb = new();
  logic [7:0] text_q[$];
  int send_idle_pct = 29;
  int recv_idle_pct = 80;
  int chars_sent = 0;
  int texts_sent = 0;
  int stall_cycles = 0;

  decimal_number_text_parser dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .char_code(char_code),
    .last_char(last_char),
    .empty(empty),
    .pop(pop),
    .negative(negative),
    .mantissa(mantissa),
    .decimal_exponent(decimal_exponent),
    .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (push && !full) sb.note_char(char_code, last_char);
      if (pop && !empty) sb.check_result(negative, mantissa, decimal_exponent, overflow);
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
        $display("decimal_number_text_parser: mismatch");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    char_code <= c;
    last_char <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    texts_sent++;
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function void add_digits(input int count);
    repeat (count) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
  endfunction

  function void build_random_text(input bit long_frac);
    int mode;
    int r;
    mode = long_frac ? 99 : $urandom_range(99);
    text_q.delete();
    if (mode < 12) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3)) begin
        r = $urandom_range(5);
        text_q.push_back(r == 5 ? CH_SPACE : 8'(CH_TAB + r));
      end
      r = $urandom_range(2);
      if (r == 0) text_q.push_back(CH_MINUS);
      else if (r == 1) text_q.push_back(CH_PLUS);
      add_digits($urandom_range(9) < 8 ? $urandom_range(6) : $urandom_range(23));
      if (long_frac || $urandom_range(1)) begin
        text_q.push_back(CH_POINT);
        if (long_frac) add_digits($urandom_range(250, 262));
        else add_digits($urandom_range(9) < 8 ? $urandom_range(6) : $urandom_range(22));
      end
      if ($urandom_range(1)) begin
        text_q.push_back($urandom_range(1) ? CH_LOWER_E : CH_UPPER_E);
        r = $urandom_range(2);
        if (r == 0) text_q.push_back(CH_MINUS);
        else if (r == 1) text_q.push_back(CH_PLUS);
        add_digits($urandom_range(9) < 8 ? $urandom_range(3) : $urandom_range(6));
      end
      if (mode < 22 && text_q.size() != 0)
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(255)));
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
  endfunction

  initial begin
    int send_pcts[3];
    int recv_pcts[3];
    int target;
    send_pcts = '{29, 80, 0};
    recv_pcts = '{80, 29, 0};
    rst <= 1'b1;
    push <= 1'b0;
    char_code <= 8'h00;
    last_char <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_string("0");
    send_string("-12.5e+3");
    send_string("+.5E-2");
    send_string(" \t\n\v\f\0157");
    send_string("999999999999999999");
    send_string("12345678901234567890.5");
    send_string("1e999");
    send_string("-1e-1000");
    send_string("5e");
    send_string("e5");
    send_string(".e-");
    send_string("- 5");
    send_string("1.2.3x");
    send_string("+-1");
    send_string("abc");
    send_string(" ");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    drain();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      target = chars_sent + CHARS_PER_PHASE;
      build_random_text(1'b1);
      send_text();
      while (chars_sent < target) begin
        build_random_text(1'b0);
        send_text();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d texts in %0d characters under three idle patterns.",
             texts_sent, chars_sent);
    $display("Checked %0d results, %0d of them saturated; %0d field errors.",
             sb.checked, sb.overflows, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("decimal_number_text_parser: match");
    end else begin
      $display("decimal_number_text_parser: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/dntp_pkg.sv
design/dntp_front.sv
design/dntp_queue.sv
design/dntp_back.sv
design/decimal_number_text_parser.sv
sim/tb.sv
